[sv/cau_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_DIV  = 3'd3;
   localparam logic [2:0] CMD_CONJ = 3'd4;
   localparam logic [2:0] CMD_EQ   = 3'd5;

   typedef struct packed {
      logic [2:0]                  cmd;
      logic signed [WORD_BITS-1:0] a_real;
      logic signed [WORD_BITS-1:0] a_imag;
      logic signed [WORD_BITS-1:0] b_real;
      logic signed [WORD_BITS-1:0] b_imag;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] res_real;
      logic signed [WORD_BITS-1:0] res_imag;
      logic                        is_equal;
      logic                        div_by_zero;
      logic                        saturated;
   } rsp_word_type;

   // queue entry: the request word plus its class
   typedef struct packed {
      req_word_type word;
      logic         is_div;
   } cau_item_type;

endpackage

`default_nettype wire

[sv/cau_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module cau_front
   import cau_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_word_type req_word,
   output logic              busy,
   output logic              head_valid,
   output cau_item_type      head_item,
   input  wire logic         pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cau_item_type     entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   cau_item_type     new_item;

   assign busy       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign push       = start & ~busy;

   // classify
   always_comb begin
      new_item.word   = req_word;
      new_item.is_div = (req_word.cmd == CMD_DIV);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

[sv/cau_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module cau_back
   import cau_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         head_valid,
   input  wire cau_item_type head_item,
   output logic              pop,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word
);

   localparam int W  = WORD_BITS;
   localparam int PW = 2 * W;
   localparam int XW = 2 * W + 1;
   localparam int NW = 2 * W;
   localparam int QW = NW + FRAC_BITS;
   localparam int CW = $clog2(QW);
   localparam logic [CW-1:0] ITER_LAST = CW'(QW - 1);

   localparam logic [1:0] DIV_IDLE = 2'd0;
   localparam logic [1:0] DIV_PREP = 2'd1;
   localparam logic [1:0] DIV_ITER = 2'd2;
   localparam logic [1:0] DIV_FIN  = 2'd3;

   function automatic logic [W:0] clamp_wide(input logic signed [XW-1:0] v);
      logic fits;
      begin
         fits = (&v[XW-1:W-1]) | ~(|v[XW-1:W-1]);
         if (fits) begin
            clamp_wide = {1'b0, v[W-1:0]};
         end else if (v[XW-1]) begin
            clamp_wide = {2'b11, {(W-1){1'b0}}};
         end else begin
            clamp_wide = {2'b10, {(W-1){1'b1}}};
         end
      end
   endfunction

   function automatic logic [W:0] clamp_quot(input logic [QW-1:0] mag, input logic neg);
      logic hi_zero;
      logic is_min;
      begin
         hi_zero = ~(|mag[QW-1:W-1]);
         is_min  = ~(|mag[QW-1:W]) & mag[W-1] & ~(|mag[W-2:0]);
         if (!neg) begin
            clamp_quot = hi_zero ? {1'b0, mag[W-1:0]} : {2'b10, {(W-1){1'b1}}};
         end else begin
            clamp_quot = (hi_zero | is_min) ? {1'b0, W'(-mag[W-1:0])}
                                            : {2'b11, {(W-1){1'b0}}};
         end
      end
   endfunction

   // one restoring step: returns {remainder, quotient shift register}
   function automatic logic [NW+QW-1:0] div_step(input logic [NW-1:0] rem,
                                                 input logic [QW-1:0] quo,
                                                 input logic [NW-1:0] den);
      logic [NW:0] trial;
      logic [NW:0] diff;
      logic        ge;
      begin
         trial    = {rem, quo[QW-1]};
         diff     = trial - {1'b0, den};
         ge       = (trial >= {1'b0, den});
         div_step = {(ge ? diff[NW-1:0] : trial[NW-1:0]), quo[QW-2:0], ge};
      end
   endfunction

   // stage 1: operands and partial products
   logic                 s1_valid_ff, s1_valid_in;
   cau_item_type         s1_item_ff, s1_item_in;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_bb_r_ff, p_bb_i_ff;
   logic signed [PW-1:0] p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_bb_r_in, p_bb_i_in;

   // divider
   logic [1:0]           div_state_ff, div_state_in;
   logic [CW-1:0]        div_cnt_ff, div_cnt_in;
   logic signed [XW-1:0] num_r_ff, num_r_in, num_i_ff, num_i_in;
   logic [NW-1:0]        den_ff, den_in;
   logic [NW-1:0]        rem_r_ff, rem_r_in, rem_i_ff, rem_i_in;
   logic [QW-1:0]        quo_r_ff, quo_r_in, quo_i_ff, quo_i_in;
   logic                 neg_r_ff, neg_r_in, neg_i_ff, neg_i_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   logic                 div_busy, s1_fire, launch, b_zero, eq_flag, dz_flag;
   logic signed [W-1:0]  ar, ai, br, bi;
   logic signed [XW-1:0] x_real, x_imag, mul_r, mul_i, abs_r, abs_i;
   logic [W:0]           cl_r, cl_i, dq_r, dq_i;
   logic [NW+QW-1:0]     step_r, step_i;

   assign ar = s1_item_ff.word.a_real;
   assign ai = s1_item_ff.word.a_imag;
   assign br = s1_item_ff.word.b_real;
   assign bi = s1_item_ff.word.b_imag;

   assign div_busy = (div_state_ff != DIV_IDLE);
   assign s1_fire  = s1_valid_ff & ~div_busy;
   assign b_zero   = (br == '0) && (bi == '0);
   assign launch   = s1_fire & s1_item_ff.is_div & ~b_zero;
   assign pop      = head_valid & (~s1_valid_ff | s1_fire);

   always_comb begin
      s1_valid_in = pop | (s1_valid_ff & ~s1_fire);
      s1_item_in  = pop ? head_item : s1_item_ff;
      p_rr_in     = p_rr_ff;
      p_ii_in     = p_ii_ff;
      p_ri_in     = p_ri_ff;
      p_ir_in     = p_ir_ff;
      p_bb_r_in   = p_bb_r_ff;
      p_bb_i_in   = p_bb_i_ff;
      if (pop) begin
         p_rr_in   = PW'(head_item.word.a_real) * PW'(head_item.word.b_real);
         p_ii_in   = PW'(head_item.word.a_imag) * PW'(head_item.word.b_imag);
         p_ri_in   = PW'(head_item.word.a_real) * PW'(head_item.word.b_imag);
         p_ir_in   = PW'(head_item.word.a_imag) * PW'(head_item.word.b_real);
         p_bb_r_in = PW'(head_item.word.b_real) * PW'(head_item.word.b_real);
         p_bb_i_in = PW'(head_item.word.b_imag) * PW'(head_item.word.b_imag);
      end
   end

   // results that finish in one pass
   always_comb begin
      x_real  = '0;
      x_imag  = '0;
      eq_flag = 1'b0;
      dz_flag = 1'b0;
      mul_r   = XW'(p_rr_ff) - XW'(p_ii_ff);
      mul_i   = XW'(p_ri_ff) + XW'(p_ir_ff);
      case (s1_item_ff.word.cmd)
         CMD_ADD: begin
            x_real = XW'(ar) + XW'(br);
            x_imag = XW'(ai) + XW'(bi);
         end
         CMD_SUB: begin
            x_real = XW'(ar) - XW'(br);
            x_imag = XW'(ai) - XW'(bi);
         end
         CMD_MUL: begin
            x_real = mul_r >>> FRAC_BITS;
            x_imag = mul_i >>> FRAC_BITS;
         end
         CMD_DIV: begin
            dz_flag = b_zero;
         end
         CMD_CONJ: begin
            x_real = XW'(ar);
            x_imag = -XW'(ai);
         end
         CMD_EQ: begin
            eq_flag = (ar == br) && (ai == bi);
         end
         default: begin
         end
      endcase
      cl_r = clamp_wide(x_real);
      cl_i = clamp_wide(x_imag);
   end

   // divider sequencer
   always_comb begin
      abs_r        = num_r_ff[XW-1] ? -num_r_ff : num_r_ff;
      abs_i        = num_i_ff[XW-1] ? -num_i_ff : num_i_ff;
      step_r       = div_step(rem_r_ff, quo_r_ff, den_ff);
      step_i       = div_step(rem_i_ff, quo_i_ff, den_ff);
      div_state_in = div_state_ff;
      div_cnt_in   = div_cnt_ff;
      num_r_in     = num_r_ff;
      num_i_in     = num_i_ff;
      den_in       = den_ff;
      rem_r_in     = rem_r_ff;
      rem_i_in     = rem_i_ff;
      quo_r_in     = quo_r_ff;
      quo_i_in     = quo_i_ff;
      neg_r_in     = neg_r_ff;
      neg_i_in     = neg_i_ff;
      case (div_state_ff)
         DIV_IDLE: begin
            if (launch) begin
               num_r_in     = XW'(p_rr_ff) + XW'(p_ii_ff);
               num_i_in     = XW'(p_ir_ff) - XW'(p_ri_ff);
               den_in       = p_bb_r_ff[NW-1:0] + p_bb_i_ff[NW-1:0];
               div_state_in = DIV_PREP;
            end
         end
         DIV_PREP: begin
            neg_r_in     = num_r_ff[XW-1];
            neg_i_in     = num_i_ff[XW-1];
            rem_r_in     = '0;
            rem_i_in     = '0;
            quo_r_in     = QW'(abs_r[NW-1:0]) << FRAC_BITS;
            quo_i_in     = QW'(abs_i[NW-1:0]) << FRAC_BITS;
            div_cnt_in   = '0;
            div_state_in = DIV_ITER;
         end
         DIV_ITER: begin
            rem_r_in   = step_r[NW+QW-1:QW];
            quo_r_in   = step_r[QW-1:0];
            rem_i_in   = step_i[NW+QW-1:QW];
            quo_i_in   = step_i[QW-1:0];
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == ITER_LAST) begin
               div_state_in = DIV_FIN;
            end
         end
         DIV_FIN: begin
            div_state_in = DIV_IDLE;
         end
         default: begin
            div_state_in = DIV_IDLE;
         end
      endcase
   end

   assign dq_r = clamp_quot(quo_r_ff, neg_r_ff);
   assign dq_i = clamp_quot(quo_i_ff, neg_i_ff);

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      if (div_state_ff == DIV_FIN) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.res_real    = dq_r[W-1:0];
         rsp_word_in.res_imag    = dq_i[W-1:0];
         rsp_word_in.is_equal    = 1'b0;
         rsp_word_in.div_by_zero = 1'b0;
         rsp_word_in.saturated   = dq_r[W] | dq_i[W];
      end else if (s1_fire && !launch) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.res_real    = cl_r[W-1:0];
         rsp_word_in.res_imag    = cl_i[W-1:0];
         rsp_word_in.is_equal    = eq_flag;
         rsp_word_in.div_by_zero = dz_flag;
         rsp_word_in.saturated   = cl_r[W] | cl_i[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         div_state_ff <= DIV_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         div_state_ff <= div_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      p_rr_ff     <= p_rr_in;
      p_ii_ff     <= p_ii_in;
      p_ri_ff     <= p_ri_in;
      p_ir_ff     <= p_ir_in;
      p_bb_r_ff   <= p_bb_r_in;
      p_bb_i_ff   <= p_bb_i_in;
      div_cnt_ff  <= div_cnt_in;
      num_r_ff    <= num_r_in;
      num_i_ff    <= num_i_in;
      den_ff      <= den_in;
      rem_r_ff    <= rem_r_in;
      rem_i_ff    <= rem_i_in;
      quo_r_ff    <= quo_r_in;
      quo_i_ff    <= quo_i_in;
      neg_r_ff    <= neg_r_in;
      neg_i_ff    <= neg_i_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_launch_prep: assert property (@(posedge clock) disable iff (reset)
      launch |=> div_state_ff == DIV_PREP)
      else $error("divider did not start after launch");

   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      div_state_ff == DIV_FIN |=> rsp_valid_ff && div_state_ff == DIV_IDLE)
      else $error("divider finish did not produce a word");

   a_quiet_iter: assert property (@(posedge clock) disable iff (reset)
      div_state_ff == DIV_ITER |-> !rsp_valid_ff && !s1_fire)
      else $error("word issued while divider iterating");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones({rsp_word_ff.is_equal, rsp_word_ff.div_by_zero,
                                   rsp_word_ff.saturated}) <= 1)
      else $error("conflicting result flags");

endmodule

`default_nettype wire

[sv/complex_arithmetic_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// add, sub, mul, conjugate, equal: request queue, product stage, then output register to rsp_valid
// divide: Q16.16 quotient from the one-bit-per-cycle restoring divider that serves both
//   result parts together, then the output register
// throughput: one word per cycle except while the divider runs, which holds the back end
// the receiver cannot stall; busy only reflects a full request queue
// reset clears the queue, the stage valids and the divider state; payload is not reset

module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2   // request queue entries between front and back
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_word_type req_word,
   output logic              busy,
   output logic              rsp_valid,
   output rsp_word_type      rsp_word
);

   // front to back queue head
   logic         head_valid;
   cau_item_type head_item;
   logic         pop;

   // front: takes words, tags divides, buffers them
   cau_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .busy       (busy),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   // back: product stage, result stage, iterative divider, output register
   cau_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire
